// ----- rtl/aimd_pkg.sv -----
// ----------------------------------------------------------------------------
// AIMD package
// Shared types and constants for the congestion window controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package aimd_pkg;

    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_CWND     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SSTHRESH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AI_STEP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MD_COEF       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SSTHRESH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE_FLAGS    = 3'd5;

    localparam logic [1:0] OP_DATA    = 2'd0;
    localparam logic [1:0] OP_LOSS    = 2'd1;
    localparam logic [1:0] OP_REQUEST = 2'd2;

    localparam int unsigned MODE_CONST_WIN   = 0;
    localparam int unsigned MODE_NO_CWA      = 1;
    localparam int unsigned MODE_RESET_INIT  = 2;
    localparam int unsigned MODE_IGNORE_MARK = 3;

    localparam logic [16:0] ONE_Q16 = 17'h10000;

    localparam logic [31:0] RST_INIT_CWND     = 32'h0001_0000;
    localparam logic [31:0] RST_INIT_SSTHRESH = 32'hFFFF_FFFF;
    localparam logic [31:0] RST_AI_STEP       = 32'h0001_0000;
    localparam logic [16:0] RST_MD_COEF       = 17'h08000;
    localparam logic [31:0] RST_MIN_SSTHRESH  = 32'h0002_0000;
    localparam logic [3:0]  RST_MODE_FLAGS    = 4'h0;

    localparam logic [5:0] MUL_STEPS = 6'd17;
    localparam logic [5:0] DIV_STEPS = 6'd32;

    typedef enum logic
    {
        ALU_MUL,
        ALU_DIV
    } alu_kind_t;

    typedef struct packed
    {
        logic        start;
        alu_kind_t   kind;
        logic [31:0] opa;
        logic [16:0] opb;
    } alu_req_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } alu_sts_t;

    typedef struct packed
    {
        logic [1:0]  op;
        logic [31:0] seg_num;
        logic        cong_mark;
    } aimd_in_t;

    typedef struct packed
    {
        logic [31:0] cwnd_q;
        logic [31:0] ssthresh_q;
        logic [15:0] window_segments;
        logic        decreased;
    } aimd_out_t;

endpackage

// ----- rtl/aimd_alu.sv -----
// ----------------------------------------------------------------------------
// AIMD shared arithmetic unit
// Bit-serial shift-add multiply (Q16.16 by Q1.16, result >> 16) and
// restoring divide (32-bit by 16-bit), one bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aimd_alu
    import aimd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  alu_req_t    req,
    output alu_sts_t    sts,
    output logic [31:0] result
);

    logic        busy_reg;
    logic        done_reg;
    alu_kind_t   kind_reg;
    logic [5:0]  cnt_reg;
    logic [48:0] acc_reg;
    logic [15:0] rem_reg;
    logic [31:0] opa_reg;
    logic [16:0] opb_reg;

    logic [48:0] mul_next;
    logic [16:0] shifted;
    logic        fits;
    logic [16:0] diff;

    always_comb
    begin
        mul_next = {acc_reg[47:0], 1'b0} + (opb_reg[16] ? {17'd0, opa_reg} : 49'd0);
        shifted  = {rem_reg, acc_reg[31]};
        fits     = shifted >= opb_reg;
        diff     = shifted - opb_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            kind_reg <= ALU_MUL;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                kind_reg <= req.kind;
                cnt_reg  <= (req.kind == ALU_MUL) ? MUL_STEPS : DIV_STEPS;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            opa_reg <= req.opa;
            opb_reg <= req.opb;
            rem_reg <= 16'd0;
            acc_reg <= (req.kind == ALU_MUL) ? 49'd0 : {17'd0, req.opa};
        end
        else if (busy_reg)
        begin
            unique case (kind_reg)
                ALU_MUL:
                begin
                    acc_reg <= mul_next;
                    opb_reg <= {opb_reg[15:0], 1'b0};
                end
                ALU_DIV:
                begin
                    rem_reg <= fits ? diff[15:0] : shifted[15:0];
                    acc_reg <= {17'd0, acc_reg[30:0], fits};
                end
            endcase
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = (kind_reg == ALU_MUL) ? acc_reg[47:16] : acc_reg[31:0];

    ap_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy_reg) |-> $past(req.start))
        else $error("unit went busy without a start");

    ap_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(busy_reg) && $past(cnt_reg == 6'd1))
        else $error("done without finishing the last step");

    ap_cnt_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != 6'd0)
        else $error("busy with an empty step count");

endmodule

// ----- rtl/aimd_congestion_window.sv -----
// Sequence: each input word passes the idle, exec and done steps to the output register;
// a decrease adds the multiply step, which runs the 17-step serial multiply, and
// congestion avoidance adds the divide step, which runs the 32-step serial divide.
// Throughput: one event at a time; the next word is taken only after the last one leaves
// the done step, which waits while a finished output word is still held by the receiver.
// Reset: asynchronous, active low; config registers take their defaults and the
// window state takes the default initial window and threshold.
// ----------------------------------------------------------------------------
// AIMD congestion window controller
// Sequencer, state registers and config registers around one shared
// serial multiply/divide unit, Q16.16 fixed point.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aimd_congestion_window
    import aimd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  aimd_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output aimd_out_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_EXEC,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t      state_reg;
    logic [31:0] init_cwnd_reg;
    logic [31:0] init_ssthresh_reg;
    logic [31:0] ai_step_reg;
    logic [16:0] md_coef_reg;
    logic [31:0] min_ssthresh_reg;
    logic [3:0]  mode_reg;

    logic [31:0] cwnd_reg;
    logic [31:0] ssthresh_reg;
    logic [31:0] recovery_reg;
    logic [31:0] high_data_reg;
    logic [31:0] high_req_reg;

    aimd_in_t    item_reg;
    logic        dec_reg;
    logic        out_valid_reg;
    aimd_out_t   out_reg;

    alu_req_t    alu_req;
    alu_sts_t    alu_sts;
    logic [31:0] alu_result;

    logic        do_shrink;
    logic        shrink_ok;
    logic        in_slow_start;
    logic [15:0] cwnd_whole;
    logic [16:0] coef_lim;
    logic [31:0] ssthresh_next;
    logic [32:0] add_slow;
    logic [32:0] add_avoid;

    always_comb
    begin
        do_shrink     = (item_reg.op == OP_LOSS) ||
                        (item_reg.op == OP_DATA && item_reg.cong_mark &&
                         !mode_reg[MODE_IGNORE_MARK]);
        shrink_ok     = mode_reg[MODE_NO_CWA] || (high_data_reg > recovery_reg);
        in_slow_start = cwnd_reg < ssthresh_reg;
        cwnd_whole    = (cwnd_reg[31:16] == 16'd0) ? 16'd1 : cwnd_reg[31:16];
        coef_lim      = (md_coef_reg > ONE_Q16) ? ONE_Q16 : md_coef_reg;
        ssthresh_next = (alu_result < min_ssthresh_reg) ? min_ssthresh_reg : alu_result;
        add_slow      = {1'b0, cwnd_reg} + {1'b0, ai_step_reg};
        add_avoid     = {1'b0, cwnd_reg} + {1'b0, alu_result};

        alu_req.start = 1'b0;
        alu_req.kind  = ALU_MUL;
        alu_req.opa   = cwnd_reg;
        alu_req.opb   = coef_lim;
        if (state_reg == ST_EXEC && !mode_reg[MODE_CONST_WIN])
        begin
            if (do_shrink)
            begin
                alu_req.start = shrink_ok;
            end
            else if (item_reg.op == OP_DATA && !in_slow_start)
            begin
                alu_req.start = 1'b1;
                alu_req.kind  = ALU_DIV;
                alu_req.opa   = ai_step_reg;
                alu_req.opb   = {1'b0, cwnd_whole};
            end
        end
    end

    aimd_alu u_alu
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .sts    (alu_sts),
        .result (alu_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_cwnd_reg     <= RST_INIT_CWND;
            init_ssthresh_reg <= RST_INIT_SSTHRESH;
            ai_step_reg       <= RST_AI_STEP;
            md_coef_reg       <= RST_MD_COEF;
            min_ssthresh_reg  <= RST_MIN_SSTHRESH;
            mode_reg          <= RST_MODE_FLAGS;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INIT_CWND:     init_cwnd_reg     <= cfg_data;
                CFG_INIT_SSTHRESH: init_ssthresh_reg <= cfg_data;
                CFG_AI_STEP:       ai_step_reg       <= cfg_data;
                CFG_MD_COEF:       md_coef_reg       <= cfg_data[16:0];
                CFG_MIN_SSTHRESH:  min_ssthresh_reg  <= cfg_data;
                CFG_MODE_FLAGS:    mode_reg          <= cfg_data[3:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cwnd_reg      <= RST_INIT_CWND;
            ssthresh_reg  <= RST_INIT_SSTHRESH;
            recovery_reg  <= 32'd0;
            high_data_reg <= 32'd0;
            high_req_reg  <= 32'd0;
            dec_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        dec_reg <= 1'b0;
                        if (in_data.op == OP_DATA && in_data.seg_num > high_data_reg)
                        begin
                            high_data_reg <= in_data.seg_num;
                        end
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_DONE;
                    if (item_reg.op == OP_REQUEST)
                    begin
                        high_req_reg <= item_reg.seg_num;
                    end
                    else if (do_shrink)
                    begin
                        if (shrink_ok)
                        begin
                            recovery_reg <= high_req_reg;
                            if (!mode_reg[MODE_CONST_WIN])
                            begin
                                state_reg <= ST_MUL;
                            end
                        end
                    end
                    else if (item_reg.op == OP_DATA && !mode_reg[MODE_CONST_WIN])
                    begin
                        if (in_slow_start)
                        begin
                            cwnd_reg <= add_slow[32] ? 32'hFFFF_FFFF : add_slow[31:0];
                        end
                        else
                        begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_MUL:
                begin
                    if (alu_sts.done)
                    begin
                        ssthresh_reg <= ssthresh_next;
                        cwnd_reg     <= mode_reg[MODE_RESET_INIT] ? init_cwnd_reg
                                                                  : ssthresh_next;
                        dec_reg      <= 1'b1;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_DIV:
                begin
                    if (alu_sts.done)
                    begin
                        cwnd_reg  <= add_avoid[32] ? 32'hFFFF_FFFF : add_avoid[31:0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
        if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
        begin
            out_reg.cwnd_q          <= cwnd_reg;
            out_reg.ssthresh_q      <= ssthresh_reg;
            out_reg.window_segments <= cwnd_reg[31:16];
            out_reg.decreased       <= dec_reg;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    ap_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("output word raised outside the done step");

    ap_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        alu_req.start |-> !alu_sts.busy && state_reg == ST_EXEC)
        else $error("unit started while busy");

    ap_const_window: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && mode_reg[MODE_CONST_WIN]) |=>
            $stable(cwnd_reg) && $stable(ssthresh_reg) && !dec_reg)
        else $error("window moved in constant-window mode");

endmodule

// ----- dv/aimd_congestion_window_test.sv -----
// ----------------------------------------------------------------------------
// AIMD congestion window controller testbench
// Drives event words with random gaps, takes result words with random stalls
// and one long hold-off, and checks every word against a built-in window
// predictor. Register settings change between traffic phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module aimd_congestion_window_test;

    import aimd_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         STALL_LIMIT = 2000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    aimd_in_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    aimd_out_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;

    // Predictor registers and window state
    logic [31:0] m_init_cwnd = RST_INIT_CWND;
    logic [31:0] m_init_ssth = RST_INIT_SSTHRESH;
    logic [31:0] m_ai        = RST_AI_STEP;
    logic [16:0] m_coef      = RST_MD_COEF;
    logic [31:0] m_min_ssth  = RST_MIN_SSTHRESH;
    logic [3:0]  m_mode      = RST_MODE_FLAGS;
    logic [31:0] cwnd        = RST_INIT_CWND;
    logic [31:0] ssth        = RST_INIT_SSTHRESH;
    logic [31:0] recov       = '0;
    logic [31:0] hi_data     = '0;
    logic [31:0] hi_req      = '0;

    aimd_in_t  pending_events[$];
    aimd_out_t reports_due[$];
    int        words_queued  = 0;
    int        words_checked = 0;
    int        faults        = 0;
    int        send_wait     = 0;
    int        recv_wait     = 0;
    bit        quiet         = 1'b0;
    bit        stall_request = 1'b0;
    logic [31:0] seg_cursor  = '0;

    aimd_congestion_window dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int draw_wait();
        return quiet ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic void window_grow();
        logic [32:0] sum;
        logic [31:0] div;
        if (m_mode[MODE_CONST_WIN])
            return;
        if (cwnd < ssth)
        begin
            sum = {1'b0, cwnd} + {1'b0, m_ai};
        end
        else
        begin
            div = (cwnd[31:16] == 16'd0) ? 32'd1 : {16'd0, cwnd[31:16]};
            sum = {1'b0, cwnd} + {1'b0, m_ai / div};
        end
        cwnd = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic logic window_cut();
        logic [16:0] coef;
        logic [48:0] prod;
        logic [31:0] scaled;
        if (!(m_mode[MODE_NO_CWA] || hi_data > recov))
            return 1'b0;
        recov = hi_req;
        if (m_mode[MODE_CONST_WIN])
            return 1'b0;
        coef   = (m_coef > ONE_Q16) ? ONE_Q16 : m_coef;
        prod   = {17'd0, cwnd} * {32'd0, coef};
        scaled = prod[47:16];
        ssth   = (scaled < m_min_ssth) ? m_min_ssth : scaled;
        cwnd   = m_mode[MODE_RESET_INIT] ? m_init_cwnd : ssth;
        return 1'b1;
    endfunction

    function automatic aimd_out_t advance_window(aimd_in_t ev);
        aimd_out_t res;
        logic      cut;
        cut = 1'b0;
        case (ev.op)
            OP_DATA:
            begin
                if (ev.seg_num > hi_data)
                    hi_data = ev.seg_num;
                if (ev.cong_mark && !m_mode[MODE_IGNORE_MARK])
                    cut = window_cut();
                else
                    window_grow();
            end
            OP_LOSS:
                cut = window_cut();
            OP_REQUEST:
                hi_req = ev.seg_num;
            default:
                ;
        endcase
        res.cwnd_q          = cwnd;
        res.ssthresh_q      = ssth;
        res.window_segments = cwnd[31:16];
        res.decreased       = cut;
        return res;
    endfunction

    function automatic void check_word(aimd_out_t got);
        aimd_out_t want;
        if (reports_due.size() == 0)
        begin
            faults++;
            if (faults <= 10)
                $display("unexpected result word %h", got);
            return;
        end
        want = reports_due.pop_front();
        words_checked++;
        if (got.cwnd_q !== want.cwnd_q || got.ssthresh_q !== want.ssthresh_q ||
            got.window_segments !== want.window_segments ||
            got.decreased !== want.decreased)
        begin
            faults++;
            if (faults <= 10)
                $display("mismatch cwnd %h/%h ssthresh %h/%h segs %h/%h dec %b/%b",
                         got.cwnd_q, want.cwnd_q, got.ssthresh_q, want.ssthresh_q,
                         got.window_segments, want.window_segments,
                         got.decreased, want.decreased);
        end
    endfunction

    // Sender: hold the word until taken, then idle for the drawn gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            in_data   <= '0;
            send_wait <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                reports_due.push_back(advance_window(in_data));
            if (!in_valid || in_ready)
            begin
                if (send_wait != 0)
                begin
                    in_valid  <= 1'b0;
                    send_wait <= send_wait - 1;
                end
                else if (pending_events.size() != 0)
                begin
                    in_data   <= pending_events.pop_front();
                    in_valid  <= 1'b1;
                    send_wait <= draw_wait();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall for the drawn count after each word
    always @(posedge clk or negedge rst_n)
    begin : recv_side
        int nxt;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            nxt = recv_wait;
            if (out_valid && out_ready)
            begin
                check_word(out_data);
                nxt = draw_wait();
            end
            else if (nxt > 0)
            begin
                nxt = nxt - 1;
            end
            if (stall_request)
            begin
                nxt           = HOLD_CYCLES;
                stall_request = 1'b0;
            end
            recv_wait <= nxt;
            out_ready <= (nxt == 0);
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready) || !rst_n)
                stuck = 0;
            else
                stuck++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic offer(input logic [1:0] op, input logic [31:0] seg, input logic mark);
        aimd_in_t ev;
        ev.op        = op;
        ev.seg_num   = seg;
        ev.cong_mark = mark;
        pending_events.push_back(ev);
        words_queued++;
    endtask

    task automatic program_regs(input logic [31:0] v_init, input logic [31:0] v_ssth,
                                input logic [31:0] v_ai, input logic [31:0] v_coef,
                                input logic [31:0] v_min, input logic [31:0] v_mode);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [31:0]          val [6];
        idx = '{CFG_INIT_CWND, CFG_INIT_SSTHRESH, CFG_AI_STEP,
                CFG_MD_COEF, CFG_MIN_SSTHRESH, CFG_MODE_FLAGS};
        val = '{v_init, v_ssth, v_ai, v_coef, v_min, v_mode};
        for (int i = 0; i < 6; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[i])
                CFG_INIT_CWND:     m_init_cwnd = val[i];
                CFG_INIT_SSTHRESH: m_init_ssth = val[i];
                CFG_AI_STEP:       m_ai        = val[i];
                CFG_MD_COEF:       m_coef      = val[i][16:0];
                CFG_MIN_SSTHRESH:  m_min_ssth  = val[i];
                CFG_MODE_FLAGS:    m_mode      = val[i][3:0];
                default:           ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_settings();
        logic [31:0] v_init, v_ssth, v_ai, v_coef, v_min, v_mode;
        case ($urandom_range(0, 3))
            0:       v_init = 32'h0001_0000;
            1:       v_init = 32'hFFFF_FFFF;
            2:       v_init = $urandom();
            default: v_init = $urandom_range(32'h0001_0000, 32'h0040_0000);
        endcase
        case ($urandom_range(0, 2))
            0:       v_ssth = 32'h0001_0000;
            1:       v_ssth = 32'hFFFF_FFFF;
            default: v_ssth = $urandom();
        endcase
        case ($urandom_range(0, 5))
            0:       v_ai = 32'd0;
            1:       v_ai = 32'hFFFF_FFFF;
            2:       v_ai = $urandom();
            default: v_ai = $urandom_range(1, 32'h0004_0000);
        endcase
        case ($urandom_range(0, 4))
            0:       v_coef = 32'd0;
            1:       v_coef = {15'd0, ONE_Q16};
            2:       v_coef = $urandom();
            default: v_coef = $urandom_range(0, 32'h0001_0000);
        endcase
        case ($urandom_range(0, 4))
            0:       v_min = 32'd0;
            1:       v_min = 32'hFFFF_FFFF;
            2:       v_min = $urandom();
            default: v_min = $urandom_range(0, 32'h0008_0000);
        endcase
        v_mode = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 15);
        program_regs(v_init, v_ssth, v_ai, v_coef, v_min, v_mode);
    endtask

    task automatic queue_traffic(input int count);
        int          pick;
        logic [1:0]  op;
        logic [31:0] seg;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                op = OP_DATA;
            else if (pick < 72)
                op = OP_LOSS;
            else if (pick < 94)
                op = OP_REQUEST;
            else
                op = OP_UNUSED;
            if ($urandom_range(0, 49) == 0)
                seg_cursor = $urandom();
            seg_cursor = seg_cursor + $urandom_range(0, 4);
            if ($urandom_range(0, 9) == 0)
                seg = $urandom();
            else if (op == OP_REQUEST)
                seg = seg_cursor + $urandom_range(0, 8);
            else
                seg = seg_cursor - $urandom_range(0, 3);
            offer(op, seg, $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic drain();
        while (words_checked != words_queued)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default settings: slow start, marks, recovery point, unused op
        offer(OP_DATA, 32'd0, 1'b0);
        offer(OP_REQUEST, 32'd10, 1'b0);
        offer(OP_DATA, 32'd1, 1'b1);
        offer(OP_DATA, 32'd2, 1'b1);
        offer(OP_LOSS, 32'd0, 1'b0);
        offer(OP_DATA, 32'd11, 1'b0);
        offer(OP_LOSS, 32'hFFFF_FFFF, 1'b1);
        offer(OP_UNUSED, 32'hA5A5_5A5A, 1'b1);
        offer(OP_REQUEST, 32'hFFFF_FFFF, 1'b0);
        offer(OP_DATA, 32'hFFFF_FFFF, 1'b1);
        drain();

        // Saturation, coefficient above one, reset to initial window
        program_regs(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0001_FFFF, 32'd0,
                     (1 << MODE_NO_CWA) | (1 << MODE_RESET_INIT));
        offer(OP_DATA, 32'd7, 1'b0);
        offer(OP_LOSS, 32'd0, 1'b0);
        offer(OP_DATA, 32'd8, 1'b0);
        offer(OP_LOSS, 32'd0, 1'b0);
        offer(OP_DATA, 32'd0, 1'b1);
        drain();

        // Zero coefficient, window below one
        program_regs(32'h0001_0000, 32'hFFFF_FFFF, 32'd100, 32'd0, 32'd0,
                     1 << MODE_NO_CWA);
        offer(OP_LOSS, 32'd0, 1'b0);
        offer(OP_DATA, 32'd0, 1'b0);
        offer(OP_DATA, 32'd0, 1'b0);
        offer(OP_DATA, 32'd9, 1'b1);
        drain();

        // Constant window with marks ignored
        program_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
                     32'h0002_0000, (1 << MODE_CONST_WIN) | (1 << MODE_IGNORE_MARK));
        offer(OP_DATA, 32'd20, 1'b1);
        offer(OP_REQUEST, 32'd30, 1'b0);
        offer(OP_LOSS, 32'd0, 1'b0);
        drain();

        program_regs(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_8000,
                     32'h0002_0000, 1 << MODE_IGNORE_MARK);
        offer(OP_DATA, 32'd40, 1'b1);
        offer(OP_LOSS, 32'd0, 1'b0);
        drain();

        for (int phase = 0; phase < 8; phase++)
        begin
            quiet = (phase == 0 || phase == 3 || $urandom_range(0, 3) == 0);
            random_settings();
            if (phase == 3)
                stall_request = 1'b1;
            queue_traffic(60);
            drain();
        end

        repeat (60) @(posedge clk);
        if (faults == 0 && reports_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
